### rtl/mqttf_pkg.sv
// mqttf_pkg: types, codes and the microcode store of the mqtt packet framer
// holds the control word layout, the program rom and the field codes
// no dependencies
package mqttf_pkg;

  // longest string section accepted, longer lengths saturate to it
  localparam int MAX_STRING_LEN = 65535;
  localparam logic [15:0] MAX_LEN = 16'(MAX_STRING_LEN);

  // remaining length never exceeds 18 bits (three varint bytes)
  localparam int REM_W = 18;

  // program counter width
  localparam int UPC_W = 6;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // configuration register indexes (paddr[2])
  localparam logic REG_KEEPALIVE = 1'b0;
  localparam logic REG_SUB_ID    = 1'b1;

  // reset values of the configuration registers
  localparam logic [15:0] KEEPALIVE_RESET = 16'd60;
  localparam logic [15:0] SUB_ID_RESET    = 16'd1;

  // highest legal qos, a qos of 3 saturates to this
  localparam logic [1:0] QOS_MAX = 2'd2;

  typedef enum logic [1:0] {
    KIND_CONNECT     = 2'd0,
    KIND_SUBSCRIBE   = 2'd1,
    KIND_UNSUBSCRIBE = 2'd2,
    KIND_PUBLISH     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DATA_IDLE  = 2'd1,
    ST_START_BUSY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_FLUSH
  } sq_state_t;

  // byte source of a control word
  typedef enum logic [4:0] {
    SRC_NONE,
    SRC_CONST,
    SRC_TYPE,
    SRC_REM0,
    SRC_REM1,
    SRC_REM2,
    SRC_FLAGS,
    SRC_KA_HI,
    SRC_KA_LO,
    SRC_SID_HI,
    SRC_SID_LO,
    SRC_L0_HI,
    SRC_L0_LO,
    SRC_L1_HI,
    SRC_L1_LO,
    SRC_L2_HI,
    SRC_L2_LO,
    SRC_PID_HI,
    SRC_PID_LO,
    SRC_QOS,
    SRC_DATA
  } src_t;

  // condition that gates both the byte and the action of a step
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NZ0,
    COND_NZ1,
    COND_NZ2,
    COND_QOS_NZ,
    COND_REM1,
    COND_REM2,
    COND_IS_SUB
  } cond_t;

  // sequencer action of a step
  typedef enum logic [2:0] {
    ACT_NEXT,
    ACT_OPEN0,
    ACT_OPEN1,
    ACT_OPEN2,
    ACT_CLOSE,
    ACT_DATA,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    src_t       src;
    cond_t      cond;
    act_t       act;
    logic [7:0] konst;
    logic       load_rem;
    logic       inc_pid;
  } uword_t;

  // program entry points
  localparam logic [UPC_W-1:0] UC_CONN = 6'd0;
  localparam logic [UPC_W-1:0] UC_PUB  = 6'd24;
  localparam logic [UPC_W-1:0] UC_SUB  = 6'd35;
  localparam logic [UPC_W-1:0] UC_DATA = 6'd46;
  localparam logic [UPC_W-1:0] UC_ERR  = 6'd47;

  function automatic uword_t uw(input src_t s, input cond_t c, input act_t a,
                                input logic [7:0] k, input logic ld, input logic inc);
    uword_t w;
    w.src      = s;
    w.cond     = c;
    w.act      = a;
    w.konst    = k;
    w.load_rem = ld;
    w.inc_pid  = inc;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [UPC_W-1:0] a);
    uword_t w;
    w = uw(SRC_NONE, COND_ALWAYS, ACT_FINISH, 8'h00, 1'b0, 1'b0);
    unique case (a)
      // connect: fixed header
      UC_CONN + 6'd0:  w = uw(SRC_TYPE,  COND_ALWAYS, ACT_NEXT, 8'h00, 1'b1, 1'b0);
      UC_CONN + 6'd1:  w = uw(SRC_REM0,  COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd2:  w = uw(SRC_REM1,  COND_REM1,   ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd3:  w = uw(SRC_REM2,  COND_REM2,   ACT_NEXT, 8'h00, 1'b0, 1'b0);
      // protocol name "MQTT" with its length, then level 4
      UC_CONN + 6'd4:  w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd5:  w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h04, 1'b0, 1'b0);
      UC_CONN + 6'd6:  w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h4D, 1'b0, 1'b0);
      UC_CONN + 6'd7:  w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h51, 1'b0, 1'b0);
      UC_CONN + 6'd8:  w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h54, 1'b0, 1'b0);
      UC_CONN + 6'd9:  w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h54, 1'b0, 1'b0);
      UC_CONN + 6'd10: w = uw(SRC_CONST, COND_ALWAYS, ACT_NEXT, 8'h04, 1'b0, 1'b0);
      UC_CONN + 6'd11: w = uw(SRC_FLAGS, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd12: w = uw(SRC_KA_HI, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd13: w = uw(SRC_KA_LO, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      // client id prefix is always sent
      UC_CONN + 6'd14: w = uw(SRC_L0_HI, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd15: w = uw(SRC_L0_LO, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd16: w = uw(SRC_NONE,  COND_NZ0,    ACT_OPEN0, 8'h00, 1'b0, 1'b0);
      // username, only when not empty
      UC_CONN + 6'd17: w = uw(SRC_L1_HI, COND_NZ1,    ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd18: w = uw(SRC_L1_LO, COND_NZ1,    ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd19: w = uw(SRC_NONE,  COND_NZ1,    ACT_OPEN1, 8'h00, 1'b0, 1'b0);
      // password, only when not empty
      UC_CONN + 6'd20: w = uw(SRC_L2_HI, COND_NZ2,    ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd21: w = uw(SRC_L2_LO, COND_NZ2,    ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd22: w = uw(SRC_NONE,  COND_NZ2,    ACT_OPEN2, 8'h00, 1'b0, 1'b0);
      UC_CONN + 6'd23: w = uw(SRC_NONE,  COND_ALWAYS, ACT_CLOSE, 8'h00, 1'b0, 1'b0);
      // publish
      UC_PUB + 6'd0:   w = uw(SRC_TYPE,  COND_ALWAYS, ACT_NEXT, 8'h00, 1'b1, 1'b0);
      UC_PUB + 6'd1:   w = uw(SRC_REM0,  COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd2:   w = uw(SRC_REM1,  COND_REM1,   ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd3:   w = uw(SRC_REM2,  COND_REM2,   ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd4:   w = uw(SRC_L0_HI, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd5:   w = uw(SRC_L0_LO, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd6:   w = uw(SRC_NONE,  COND_NZ0,    ACT_OPEN0, 8'h00, 1'b0, 1'b0);
      // packet id after the topic when qos is above zero
      UC_PUB + 6'd7:   w = uw(SRC_PID_HI, COND_QOS_NZ, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd8:   w = uw(SRC_PID_LO, COND_QOS_NZ, ACT_NEXT, 8'h00, 1'b0, 1'b1);
      UC_PUB + 6'd9:   w = uw(SRC_NONE,  COND_NZ1,    ACT_OPEN1, 8'h00, 1'b0, 1'b0);
      UC_PUB + 6'd10:  w = uw(SRC_NONE,  COND_ALWAYS, ACT_CLOSE, 8'h00, 1'b0, 1'b0);
      // subscribe and unsubscribe
      UC_SUB + 6'd0:   w = uw(SRC_TYPE,  COND_ALWAYS, ACT_NEXT, 8'h00, 1'b1, 1'b0);
      UC_SUB + 6'd1:   w = uw(SRC_REM0,  COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd2:   w = uw(SRC_REM1,  COND_REM1,   ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd3:   w = uw(SRC_REM2,  COND_REM2,   ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd4:   w = uw(SRC_SID_HI, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd5:   w = uw(SRC_SID_LO, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd6:   w = uw(SRC_L0_HI, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd7:   w = uw(SRC_L0_LO, COND_ALWAYS, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd8:   w = uw(SRC_NONE,  COND_NZ0,    ACT_OPEN0, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd9:   w = uw(SRC_QOS,   COND_IS_SUB, ACT_NEXT, 8'h00, 1'b0, 1'b0);
      UC_SUB + 6'd10:  w = uw(SRC_NONE,  COND_ALWAYS, ACT_CLOSE, 8'h00, 1'b0, 1'b0);
      // one string byte through; after a section's last byte, resume after its open step
      UC_DATA:         w = uw(SRC_DATA,  COND_ALWAYS, ACT_DATA, 8'h00, 1'b0, 1'b0);
      // error result: a zero byte, state untouched
      UC_ERR:          w = uw(SRC_CONST, COND_ALWAYS, ACT_FINISH, 8'h00, 1'b0, 1'b0);
      default:         w = uw(SRC_NONE,  COND_ALWAYS, ACT_FINISH, 8'h00, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

### rtl/mqtt_control_packet_framer_top.sv
// mqtt_control_packet_framer_top: mqtt 3.1.1 packet framer, byte stream out
// microcoded sequencer over a small datapath, apb-style register port
// depends on mqttf_pkg (control word layout and program rom)

// A start item (tuser 0) opens a CONNECT, SUBSCRIBE, UNSUBSCRIBE or PUBLISH
// packet and produces the fixed header, the variable header and the length
// prefix of the first string; each data item (tuser 1) passes one string byte
// and whatever follows a finished section. Items are taken one at a time: the
// sequencer runs one program step per cycle, and a run ends in a flush state
// that hands its last byte out before the input is ready again.
// Every step waits while the output register is held by a stalled consumer.
// Errors answer a data item while no packet is open or a start item while one
// is, with a single zero byte and a status code.
module mqtt_control_packet_framer_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // kind[1:0] qos[3:2] first_len[19:4]
                                 // second_len[35:20] third_len[51:36] data_byte[59:52]
  input  logic [0:0]  s_tuser,   // cmd[0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,   // last_of_run
  output logic [2:0]  m_tuser,   // packet_end[0] status[2:1]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mqttf_pkg::sq_state_t sq_state, sq_next;
  logic [mqttf_pkg::UPC_W-1:0] upc, upc_next, resume, entry;
  mqttf_pkg::uword_t word;

  logic               phase;
  mqttf_pkg::kind_t   kind;
  logic [1:0]         qos;
  logic [15:0]        len0, len1, len2, left;
  logic [mqttf_pkg::REM_W-1:0] rem, rem_calc;
  logic [15:0]        publish_id, keepalive, sub_id;
  logic [7:0]         data_q, pend_byte, step_byte;
  logic               pend_v, close_q;
  mqttf_pkg::status_t status_q, entry_status;

  logic s_acc, out_free, cond_ok, emit, step, out_push, open_hit, cfg_wr;
  logic nz0, nz1, nz2, qnz;

  // input field views
  mqttf_pkg::kind_t in_kind;
  logic [1:0]  in_qos;
  logic [15:0] in_l0, in_l1, in_l2;

  assign in_kind = mqttf_pkg::kind_t'(s_tdata[1:0]);
  assign in_qos  = s_tdata[3:2];
  assign in_l0   = s_tdata[19:4];
  assign in_l1   = s_tdata[35:20];
  assign in_l2   = s_tdata[51:36];

  // handshakes
  assign s_tready = (sq_state == mqttf_pkg::SQ_IDLE);
  assign s_acc    = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;

  // register read
  assign prdata = (paddr[2] == mqttf_pkg::REG_SUB_ID) ? {16'b0, sub_id} : {16'b0, keepalive};

  // control word of the current step
  assign word = mqttf_pkg::ucode(upc);

  assign nz0 = (len0 != 16'd0);
  assign nz1 = (len1 != 16'd0);
  assign nz2 = (len2 != 16'd0);
  assign qnz = (qos != 2'd0);

  // step condition
  always_comb begin
    case (word.cond)
      mqttf_pkg::COND_ALWAYS: cond_ok = 1'b1;
      mqttf_pkg::COND_NZ0:    cond_ok = nz0;
      mqttf_pkg::COND_NZ1:    cond_ok = nz1;
      mqttf_pkg::COND_NZ2:    cond_ok = nz2;
      mqttf_pkg::COND_QOS_NZ: cond_ok = qnz;
      mqttf_pkg::COND_REM1:   cond_ok = (rem[mqttf_pkg::REM_W-1:7] != '0);
      mqttf_pkg::COND_REM2:   cond_ok = (rem[mqttf_pkg::REM_W-1:14] != '0);
      mqttf_pkg::COND_IS_SUB: cond_ok = (kind == mqttf_pkg::KIND_SUBSCRIBE);
      default:                cond_ok = 1'b0;
    endcase
  end

  // byte source select
  always_comb begin
    case (word.src)
      mqttf_pkg::SRC_CONST: step_byte = word.konst;
      mqttf_pkg::SRC_TYPE: begin
        case (kind)
          mqttf_pkg::KIND_CONNECT:   step_byte = 8'h10;
          mqttf_pkg::KIND_SUBSCRIBE: step_byte = 8'h82;
          mqttf_pkg::KIND_PUBLISH:   step_byte = {5'b00110, qos, 1'b0};
          default:                   step_byte = 8'hA2;
        endcase
      end
      mqttf_pkg::SRC_REM0:   step_byte = {(rem[mqttf_pkg::REM_W-1:7] != '0), rem[6:0]};
      mqttf_pkg::SRC_REM1:   step_byte = {(rem[mqttf_pkg::REM_W-1:14] != '0), rem[13:7]};
      mqttf_pkg::SRC_REM2:   step_byte = 8'(rem[mqttf_pkg::REM_W-1:14]);
      mqttf_pkg::SRC_FLAGS:  step_byte = {nz1, nz2, 6'b000010};
      mqttf_pkg::SRC_KA_HI:  step_byte = keepalive[15:8];
      mqttf_pkg::SRC_KA_LO:  step_byte = keepalive[7:0];
      mqttf_pkg::SRC_SID_HI: step_byte = sub_id[15:8];
      mqttf_pkg::SRC_SID_LO: step_byte = sub_id[7:0];
      mqttf_pkg::SRC_L0_HI:  step_byte = len0[15:8];
      mqttf_pkg::SRC_L0_LO:  step_byte = len0[7:0];
      mqttf_pkg::SRC_L1_HI:  step_byte = len1[15:8];
      mqttf_pkg::SRC_L1_LO:  step_byte = len1[7:0];
      mqttf_pkg::SRC_L2_HI:  step_byte = len2[15:8];
      mqttf_pkg::SRC_L2_LO:  step_byte = len2[7:0];
      mqttf_pkg::SRC_PID_HI: step_byte = publish_id[15:8];
      mqttf_pkg::SRC_PID_LO: step_byte = publish_id[7:0];
      mqttf_pkg::SRC_QOS:    step_byte = {6'b0, qos};
      mqttf_pkg::SRC_DATA:   step_byte = data_q;
      default:               step_byte = 8'h00;
    endcase
  end

  // remaining length of the packet being opened
  always_comb begin
    logic [mqttf_pkg::REM_W-1:0] base, t1, t2;
    case (kind)
      mqttf_pkg::KIND_CONNECT:   base = mqttf_pkg::REM_W'(12);
      mqttf_pkg::KIND_SUBSCRIBE: base = mqttf_pkg::REM_W'(5);
      mqttf_pkg::KIND_PUBLISH:   base = qnz ? mqttf_pkg::REM_W'(4) : mqttf_pkg::REM_W'(2);
      default:                   base = mqttf_pkg::REM_W'(4);
    endcase
    t1 = '0;
    t2 = '0;
    if (kind == mqttf_pkg::KIND_CONNECT) begin
      if (nz1) t1 = mqttf_pkg::REM_W'(len1) + mqttf_pkg::REM_W'(2);
      if (nz2) t2 = mqttf_pkg::REM_W'(len2) + mqttf_pkg::REM_W'(2);
    end else if (kind == mqttf_pkg::KIND_PUBLISH) begin
      t1 = mqttf_pkg::REM_W'(len1);
    end
    rem_calc = base + mqttf_pkg::REM_W'(len0) + t1 + t2;
  end

  // program entry for an accepted item
  always_comb begin
    entry        = mqttf_pkg::UC_ERR;
    entry_status = mqttf_pkg::ST_OK;
    if (s_tuser[0] == mqttf_pkg::CMD_START) begin
      if (phase) begin
        entry_status = mqttf_pkg::ST_START_BUSY;
      end else begin
        case (in_kind)
          mqttf_pkg::KIND_CONNECT: entry = mqttf_pkg::UC_CONN;
          mqttf_pkg::KIND_PUBLISH: entry = mqttf_pkg::UC_PUB;
          default:                 entry = mqttf_pkg::UC_SUB;
        endcase
      end
    end else begin
      if (phase) begin
        entry = mqttf_pkg::UC_DATA;
      end else begin
        entry_status = mqttf_pkg::ST_DATA_IDLE;
      end
    end
  end

  assign step     = (sq_state == mqttf_pkg::SQ_RUN) & out_free;
  assign emit     = (word.src != mqttf_pkg::SRC_NONE) & cond_ok;
  assign open_hit = cond_ok & ((word.act == mqttf_pkg::ACT_OPEN0) |
                               (word.act == mqttf_pkg::ACT_OPEN1) |
                               (word.act == mqttf_pkg::ACT_OPEN2));
  assign out_push = (step & emit & pend_v) |
                    ((sq_state == mqttf_pkg::SQ_FLUSH) & out_free);

  // sequencer next state and step counter
  always_comb begin
    sq_next  = sq_state;
    upc_next = upc;
    unique case (sq_state)
      mqttf_pkg::SQ_IDLE: begin
        if (s_acc) begin
          sq_next  = mqttf_pkg::SQ_RUN;
          upc_next = entry;
        end
      end
      mqttf_pkg::SQ_RUN: begin
        if (out_free) begin
          upc_next = upc + mqttf_pkg::UPC_W'(1);
          case (word.act)
            mqttf_pkg::ACT_CLOSE, mqttf_pkg::ACT_FINISH: sq_next = mqttf_pkg::SQ_FLUSH;
            mqttf_pkg::ACT_DATA: begin
              if (left == 16'd1) upc_next = resume;
              else sq_next = mqttf_pkg::SQ_FLUSH;
            end
            default: begin
              if (open_hit) sq_next = mqttf_pkg::SQ_FLUSH;
            end
          endcase
        end
      end
      mqttf_pkg::SQ_FLUSH: begin
        if (out_free) sq_next = mqttf_pkg::SQ_IDLE;
      end
      default: sq_next = mqttf_pkg::SQ_IDLE;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_state <= mqttf_pkg::SQ_IDLE;
    end else begin
      sq_state <= sq_next;
    end
  end

  // step counter, parked on the error entry until the first item
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mqttf_pkg::UC_ERR;
    end else begin
      upc <= upc_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive <= mqttf_pkg::KEEPALIVE_RESET;
      sub_id    <= mqttf_pkg::SUB_ID_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == mqttf_pkg::REG_KEEPALIVE) keepalive <= pwdata[15:0];
      else sub_id <= pwdata[15:0];
    end
  end

  // item capture at accept
  always_ff @(posedge clk) begin
    if (s_acc) begin
      data_q   <= s_tdata[59:52];
      status_q <= entry_status;
      if (entry_status == mqttf_pkg::ST_OK && s_tuser[0] == mqttf_pkg::CMD_START) begin
        kind <= in_kind;
        qos  <= (in_qos > mqttf_pkg::QOS_MAX) ? mqttf_pkg::QOS_MAX : in_qos;
        len0 <= (in_l0 > mqttf_pkg::MAX_LEN) ? mqttf_pkg::MAX_LEN : in_l0;
        len1 <= (in_l1 > mqttf_pkg::MAX_LEN) ? mqttf_pkg::MAX_LEN : in_l1;
        len2 <= (in_l2 > mqttf_pkg::MAX_LEN) ? mqttf_pkg::MAX_LEN : in_l2;
      end
    end
    if (step && word.load_rem) rem <= rem_calc;
  end

  // section tracking and packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 1'b0;
      publish_id <= 16'd0;
      close_q    <= 1'b0;
    end else begin
      if (s_acc) close_q <= 1'b0;
      if (step) begin
        if (emit && word.inc_pid) publish_id <= publish_id + 16'd1;
        if (open_hit) begin
          phase  <= 1'b1;
          resume <= upc + mqttf_pkg::UPC_W'(1);
        end
        case (word.act)
          mqttf_pkg::ACT_OPEN0: if (cond_ok) left <= len0;
          mqttf_pkg::ACT_OPEN1: if (cond_ok) left <= len1;
          mqttf_pkg::ACT_OPEN2: if (cond_ok) left <= len2;
          mqttf_pkg::ACT_DATA:  left <= left - 16'd1;
          mqttf_pkg::ACT_CLOSE: begin
            phase   <= 1'b0;
            close_q <= 1'b1;
            left    <= 16'd0;
          end
          default: ;
        endcase
      end
    end
  end

  // one-byte hold so the last byte of a run can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (step && emit) begin
      pend_v <= 1'b1;
    end else if (sq_state == mqttf_pkg::SQ_FLUSH && out_free) begin
      pend_v <= 1'b0;
    end
    if (step && emit) pend_byte <= step_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_push) begin
      m_tdata <= pend_byte;
      m_tlast <= (sq_state == mqttf_pkg::SQ_FLUSH);
      m_tuser <= {status_q, (sq_state == mqttf_pkg::SQ_FLUSH) & close_q};
    end
  end

endmodule
